// File: src/bmrs_pkg.sv
// ----------------------------------------------------------------------------
// bmrs_pkg
// shared types, constants and the trig table for the bitmap rotate block
// ----------------------------------------------------------------------------
package bmrs_pkg;

  localparam int IMAGE_SIZE     = 112;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int ROW_BYTES      = (IMAGE_SIZE + 7) / 8;
  localparam int STORE_BYTES    = IMAGE_SIZE * ROW_BYTES;
  localparam int CENTRE         = IMAGE_SIZE / 2 - 1;
  localparam int DEGREES        = 360;
  localparam int QUARTER_TURN   = 90;

  localparam int PIX_W  = $clog2(IMAGE_SIZE);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int ACC_W  = TRIG_FRAC_BITS + PIX_W + 4;
  localparam int DEG_W  = 9;
  localparam int IDX_W  = 11;
  localparam int MAJORITY = 5;

  // pi in q60 over 180, one degree in q60
  localparam longint unsigned PI_Q60_PER_DEG = 64'h3243F6A8885A308D / 64'd180;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_DATA = 1'b1
  } kind_pad_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  byte_index;
    logic [7:0]        byte_value;
    logic [DEG_W-1:0]  angle;
  } bmrs_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] read_byte;
  } bmrs_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_INIT,
    ST_MAP_RD,
    ST_MAP_WR,
    ST_SM_RD,
    ST_SM_WAIT,
    ST_SM_WR,
    ST_READ
  } state_e;

  typedef struct packed {
    logic sweep_we;
    logic sweep_ones;
    logic load;
    logic trig_load;
    logic acc_init;
    logic map_rd;
    logic map_wr;
    logic sm_init;
    logic sm_rd;
    logic sm_wr;
    logic rd_issue;
    logic rd_done;
    logic ack;
  } bmrs_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic map_last;
    logic k_last;
    logic sm_last;
  } bmrs_stat_t;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [DEGREES];

  // quotient by shift and subtract
  function automatic longint unsigned shift_sub_div(longint unsigned num,
                                                    longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sine of 0..90 degrees in unsigned q30, taylor series
  function automatic longint unsigned quarter_sin_q30(int deg);
    longint unsigned x;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned dv;
    x = (PI_Q60_PER_DEG * longint'(deg) + (64'd1 << 29)) >> 30;
    sum = x;
    term = x;
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      dv = longint'(2 * n) * longint'(2 * n + 1);
      term = shift_sub_div(term, dv);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic signed [TRIG_W-1:0] table_sin(int d);
    int q;
    logic neg;
    longint unsigned mag;
    neg = 1'b0;
    if (d <= 90) begin
      q = d;
    end else if (d <= 180) begin
      q = 180 - d;
    end else if (d <= 270) begin
      q = d - 180;
      neg = 1'b1;
    end else begin
      q = 360 - d;
      neg = 1'b1;
    end
    mag = (quarter_sin_q30(q) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return neg ? -TRIG_W'(mag) : TRIG_W'(mag);
  endfunction

  function automatic trig_tab_t build_sin_tab();
    trig_tab_t t;
    for (int d = 0; d < DEGREES; d++) begin
      t[d] = table_sin(d);
    end
    return t;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin_tab();

endpackage

// File: src/bitmap_rotate_smooth.sv
// ----------------------------------------------------------------------------
// bitmap_rotate_smooth
// 112x112 one-bit bitmap rotation with majority smoothing
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  command   start_i, in_i             taken when start_i and not busy_o
//  result    done_o, out_o             one-cycle strobe, no back-pressure
//
//  after reset a clearing sweep zeroes all 1568 bytes of the result store (busy)
//  load: no word out; read: the addressed word comes out with done_o
//  rotate: fill the result store with ones, set up, a read and a write per source
//  pixel, then a window of reads, a wait and a write per interior pixel
//  angle 0 or 360 and above: acknowledged, store untouched
// ----------------------------------------------------------------------------
module bitmap_rotate_smooth
  import bmrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  bmrs_in_t  in_i,
  output logic      busy_o,
  output logic      done_o,
  output bmrs_out_t out_o
);

  bmrs_cmd_t  cmd;
  bmrs_stat_t stat;

  bmrs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .stat_i (stat),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  bmrs_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .in_i  (in_i),
    .stat_o(stat),
    .done_o(done_o),
    .out_o (out_o)
  );

endmodule

// File: src/bmrs_datapath.sv
// ----------------------------------------------------------------------------
// bmrs_datapath
// bitmap stores, mapping accumulators, smoothing window and result register
// ----------------------------------------------------------------------------
module bmrs_datapath
  import bmrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bmrs_cmd_t  cmd_i,
  input  bmrs_in_t   in_i,
  output bmrs_stat_t stat_o,
  output logic       done_o,
  output bmrs_out_t  out_o
);

  localparam logic signed [ACC_W-1:0] Half   = ACC_W'(2 ** (TRIG_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] Base   = ACC_W'(CENTRE * (2 ** TRIG_FRAC_BITS));
  localparam logic signed [ACC_W-1:0] Cen    = ACC_W'(CENTRE);
  localparam logic signed [ACC_W-1:0] Size   = ACC_W'(IMAGE_SIZE);
  localparam logic [PIX_W-1:0]        PixMax = PIX_W'(IMAGE_SIZE - 1);
  localparam logic [PIX_W-1:0]        SmMax  = PIX_W'(IMAGE_SIZE - 2);

  logic [7:0] src_mem [STORE_BYTES];
  logic [7:0] res_mem [STORE_BYTES];
  logic [7:0] src_rd_q, res_rd_q;

  logic [ADDR_W-1:0] sweep_q;
  logic [PIX_W-1:0]  row_q, col_q;
  logic signed [ACC_W-1:0]  x_q, y_q, xr_q, yr_q;
  logic signed [TRIG_W-1:0] sin_q, cos_q;
  logic [1:0] dr_q, dc_q;
  logic [3:0] sum_q;
  logic       acc_q, ctr_acc_q;
  logic [2:0] nb_bit_q;
  logic [7:0] ctr_byte_q;
  logic       dest_ok_q;
  logic [ADDR_W-1:0] dest_addr_q;
  logic [2:0] dest_bit_q, src_bit_q;
  logic       rd_oob_q;
  logic       done_q;
  bmrs_out_t  out_q;

  logic signed [ACC_W-1:0] xs, ys, xi, yi, sin_w, cos_w;
  logic       x_ok, y_ok;
  logic [PIX_W-1:0]  xc, yr, nb_row, nb_col;
  logic [ADDR_W-1:0] cur_addr, nb_addr, dest_addr, res_raddr, res_waddr, idx_addr;
  logic       idx_ok;
  logic       res_we;
  logic [7:0] res_wdata, map_byte, sm_byte;
  logic [DEG_W:0] a90, cos_idx;
  logic [2:0] ctr_bit;

  assign sin_w = ACC_W'(sin_q);
  assign cos_w = ACC_W'(cos_q);

  assign xs = x_q + Half;
  assign ys = y_q + Half;
  assign xi = xs >>> TRIG_FRAC_BITS;
  assign yi = ys >>> TRIG_FRAC_BITS;
  assign x_ok = x_q[ACC_W-1] ? (xs > 0) : (xi < Size);
  assign y_ok = y_q[ACC_W-1] ? (ys > 0) : (yi < Size);
  assign xc = x_q[ACC_W-1] ? '0 : xi[PIX_W-1:0];
  assign yr = y_q[ACC_W-1] ? '0 : yi[PIX_W-1:0];
  assign dest_addr = ADDR_W'(yr) * ADDR_W'(ROW_BYTES) + ADDR_W'(xc >> 3);

  assign cur_addr = ADDR_W'(row_q) * ADDR_W'(ROW_BYTES) + ADDR_W'(col_q >> 3);
  assign nb_row   = row_q + PIX_W'(dr_q) - PIX_W'(1);
  assign nb_col   = col_q + PIX_W'(dc_q) - PIX_W'(1);
  assign nb_addr  = ADDR_W'(nb_row) * ADDR_W'(ROW_BYTES) + ADDR_W'(nb_col >> 3);
  assign ctr_bit  = ~col_q[2:0];

  assign idx_ok   = in_i.byte_index < IDX_W'(STORE_BYTES);
  assign idx_addr = ADDR_W'(in_i.byte_index);

  assign a90     = {1'b0, in_i.angle} + (DEG_W + 1)'(QUARTER_TURN);
  assign cos_idx = (a90 >= (DEG_W + 1)'(DEGREES)) ? a90 - (DEG_W + 1)'(DEGREES) : a90;

  always_comb begin
    map_byte = res_rd_q;
    map_byte[dest_bit_q] = src_rd_q[src_bit_q];
    sm_byte = ctr_byte_q;
    sm_byte[ctr_bit] = (sum_q >= 4'(MAJORITY));
  end

  always_comb begin
    if (cmd_i.map_rd) begin
      res_raddr = dest_addr;
    end else if (cmd_i.sm_rd) begin
      res_raddr = nb_addr;
    end else begin
      res_raddr = idx_addr;
    end
    res_we    = 1'b0;
    res_waddr = sweep_q;
    res_wdata = cmd_i.sweep_ones ? 8'hFF : 8'h00;
    if (cmd_i.sweep_we) begin
      res_we = 1'b1;
    end else if (cmd_i.map_wr) begin
      res_we    = dest_ok_q;
      res_waddr = dest_addr_q;
      res_wdata = map_byte;
    end else if (cmd_i.sm_wr) begin
      res_we    = ctr_byte_q[ctr_bit];
      res_waddr = cur_addr;
      res_wdata = sm_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && idx_ok) begin
      src_mem[idx_addr] <= in_i.byte_value;
    end
    src_rd_q <= src_mem[cur_addr];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    res_rd_q <= res_mem[res_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= '0;
      row_q     <= '0;
      col_q     <= '0;
      dr_q      <= '0;
      dc_q      <= '0;
      sum_q     <= '0;
      acc_q     <= 1'b0;
      ctr_acc_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      acc_q     <= cmd_i.sm_rd;
      ctr_acc_q <= cmd_i.sm_rd && (dr_q == 2'd1) && (dc_q == 2'd1);
      done_q    <= cmd_i.ack || cmd_i.rd_done;
      if (cmd_i.sweep_we) begin
        sweep_q <= stat_o.sweep_last ? '0 : sweep_q + ADDR_W'(1);
      end
      if (cmd_i.acc_init) begin
        row_q <= '0;
        col_q <= '0;
      end else if (cmd_i.sm_init) begin
        row_q <= PIX_W'(1);
        col_q <= PIX_W'(1);
        sum_q <= '0;
      end else if (cmd_i.map_wr) begin
        if (col_q == PixMax) begin
          col_q <= '0;
          row_q <= row_q + PIX_W'(1);
        end else begin
          col_q <= col_q + PIX_W'(1);
        end
      end else if (cmd_i.sm_wr) begin
        sum_q <= '0;
        if (col_q == SmMax) begin
          col_q <= PIX_W'(1);
          row_q <= row_q + PIX_W'(1);
        end else begin
          col_q <= col_q + PIX_W'(1);
        end
      end
      if (cmd_i.sm_rd) begin
        if (dc_q == 2'd2) begin
          dc_q <= '0;
          dr_q <= (dr_q == 2'd2) ? 2'd0 : dr_q + 2'd1;
        end else begin
          dc_q <= dc_q + 2'd1;
        end
      end
      if (acc_q) begin
        sum_q <= sum_q + 4'(res_rd_q[nb_bit_q]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.trig_load) begin
      sin_q <= SIN_TAB[in_i.angle];
      cos_q <= SIN_TAB[cos_idx[DEG_W-1:0]];
    end
    if (cmd_i.acc_init) begin
      x_q  <= Base - Cen * cos_w + Cen * sin_w;
      y_q  <= Base - Cen * sin_w - Cen * cos_w;
      xr_q <= Base - Cen * cos_w + Cen * sin_w;
      yr_q <= Base - Cen * sin_w - Cen * cos_w;
    end else if (cmd_i.map_wr) begin
      if (col_q == PixMax) begin
        xr_q <= xr_q - sin_w;
        yr_q <= yr_q + cos_w;
        x_q  <= xr_q - sin_w;
        y_q  <= yr_q + cos_w;
      end else begin
        x_q <= x_q + cos_w;
        y_q <= y_q + sin_w;
      end
    end
    if (cmd_i.map_rd) begin
      dest_ok_q   <= x_ok && y_ok;
      dest_addr_q <= dest_addr;
      dest_bit_q  <= ~xc[2:0];
      src_bit_q   <= ~col_q[2:0];
    end
    if (cmd_i.sm_rd) begin
      nb_bit_q <= ~nb_col[2:0];
    end
    if (ctr_acc_q) begin
      ctr_byte_q <= res_rd_q;
    end
    if (cmd_i.rd_issue) begin
      rd_oob_q <= !idx_ok;
    end
    if (cmd_i.ack) begin
      out_q.kind      <= KIND_ACK;
      out_q.read_byte <= 8'h00;
    end else if (cmd_i.rd_done) begin
      out_q.kind      <= KIND_DATA;
      out_q.read_byte <= rd_oob_q ? 8'h00 : res_rd_q;
    end
  end

  assign stat_o.sweep_last = (sweep_q == ADDR_W'(STORE_BYTES - 1));
  assign stat_o.map_last   = (row_q == PixMax) && (col_q == PixMax);
  assign stat_o.k_last     = (dr_q == 2'd2) && (dc_q == 2'd2);
  assign stat_o.sm_last    = (row_q == SmMax) && (col_q == SmMax);

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

// File: src/bmrs_ctrl.sv
// ----------------------------------------------------------------------------
// bmrs_ctrl
// sequencer for clearing, loading, filling, mapping, smoothing and word reads
// ----------------------------------------------------------------------------
module bmrs_ctrl
  import bmrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  bmrs_in_t   in_i,
  input  bmrs_stat_t stat_i,
  output logic       busy_o,
  output bmrs_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   angle_ok;

  assign angle_ok = (in_i.angle != '0) && (in_i.angle < DEG_W'(DEGREES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep_we = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (in_i.cmd)
            CMD_LOAD: begin
              cmd_o.load = 1'b1;
            end
            CMD_ROTATE: begin
              if (angle_ok) begin
                cmd_o.trig_load = 1'b1;
                state_d = ST_FILL;
              end else begin
                cmd_o.ack = 1'b1;
              end
            end
            CMD_READ: begin
              cmd_o.rd_issue = 1'b1;
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.sweep_we   = 1'b1;
        cmd_o.sweep_ones = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.acc_init = 1'b1;
        state_d = ST_MAP_RD;
      end
      ST_MAP_RD: begin
        cmd_o.map_rd = 1'b1;
        state_d = ST_MAP_WR;
      end
      ST_MAP_WR: begin
        cmd_o.map_wr = 1'b1;
        if (stat_i.map_last) begin
          state_d = ST_SM_RD;
        end else begin
          state_d = ST_MAP_RD;
        end
      end
      ST_SM_RD: begin
        cmd_o.sm_rd = 1'b1;
        if (stat_i.k_last) begin
          state_d = ST_SM_WAIT;
        end
      end
      ST_SM_WAIT: begin
        state_d = ST_SM_WR;
      end
      ST_SM_WR: begin
        cmd_o.sm_wr = 1'b1;
        if (stat_i.sm_last) begin
          cmd_o.ack = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SM_RD;
        end
      end
      ST_READ: begin
        cmd_o.rd_done = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // map_wr on the last pixel also primes the smoothing counters
    if (state_q == ST_MAP_WR && stat_i.map_last) begin
      cmd_o.sm_init = 1'b1;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_rot_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.cmd == CMD_ROTATE && angle_ok |=> state_q == ST_FILL)
    else $error("rotate did not start the fill sweep");

  a_sm_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SM_WR |-> $past(state_q) == ST_SM_WAIT)
    else $error("smoothing write without a completed window");

  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_done |-> $past(cmd_o.rd_issue))
    else $error("read word without an issued address");

endmodule
